@@ src/pcm_sample_format_converter_macros.svh @@
// assertion macros for the pcm sample format converter
`ifndef PCM_SAMPLE_FORMAT_CONVERTER_MACROS_SVH
`define PCM_SAMPLE_FORMAT_CONVERTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PSFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PSFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/psfc_pkg.sv @@
// shared types and constants for the pcm sample format converter
`timescale 1ns / 1ps
`default_nettype none
package psfc_pkg;
    localparam logic [1:0] FMT_S16 = 2'd0;
    localparam logic [1:0] FMT_S32 = 2'd1;
    localparam logic [1:0] FMT_FLT = 2'd2;
    localparam logic       TGT_S16 = 1'b0;
    localparam logic       TGT_S32 = 1'b1;
    localparam logic       STATUS_OK    = 1'b0;
    localparam logic       STATUS_UNSUP = 1'b1;
    localparam logic       REG_SOURCE = 1'b0;
    localparam logic       REG_TARGET = 1'b1;

    typedef struct packed {
        logic [31:0] sample_word;
        logic        planar_source;
    } t_in;

    typedef struct packed {
        logic signed [31:0] converted_sample;
        logic               status;
    } t_out;
endpackage
`default_nettype wire

@@ src/psfc_conv.sv @@
// combinational sample conversion for one sample
`timescale 1ns / 1ps
`default_nettype none
module psfc_conv (
    input  wire psfc_pkg::t_in  i_in,
    input  wire logic [1:0]     i_src_fmt,
    input  wire logic           i_tgt_fmt,
    output psfc_pkg::t_out      o_out
);
    logic [7:0]  w_exp;
    logic [23:0] w_mant;
    logic [38:0] w_prod;
    logic        w_hi;
    logic        w_up;
    logic [39:0] w_base;
    logic [39:0] w_rnd;
    logic [7:0]  w_sh;
    logic [39:0] w_shifted;
    logic [15:0] w_mag;
    logic        w_nan;
    logic        w_gt1;
    logic [15:0] w_f16;
    logic [31:0] w_w;

    assign w_w    = i_in.sample_word;
    assign w_exp  = w_w[30:23];
    assign w_mant = {1'b1, w_w[22:0]};
    assign w_prod = 39'(w_mant) * 39'(15'd32767);
    assign w_hi   = w_prod[38];

    always_comb begin
        if (w_hi) begin
            w_up   = w_prod[14] & ((|w_prod[13:0]) | w_prod[15]);
            w_base = {1'b0, w_prod[38:15], 15'b0};
            w_rnd  = w_base + (w_up ? 40'(1) << 15 : 40'd0);
        end else begin
            w_up   = w_prod[13] & ((|w_prod[12:0]) | w_prod[14]);
            w_base = {1'b0, w_prod[38:14], 14'b0};
            w_rnd  = w_base + (w_up ? 40'(1) << 14 : 40'd0);
        end
    end

    assign w_sh      = 8'd150 - w_exp;
    assign w_shifted = (w_sh >= 8'd40) ? 40'd0 : (w_rnd >> w_sh);
    assign w_mag     = w_shifted[15:0];
    assign w_nan     = (w_exp == 8'hFF) && (w_w[22:0] != 23'd0);
    assign w_gt1     = w_w[30:0] > 31'h3F80_0000;

    always_comb begin
        if (w_nan || w_exp == 8'd0) begin
            w_f16 = 16'd0;
        end else if (w_gt1) begin
            w_f16 = w_w[31] ? 16'h8000 : 16'h7FFF;
        end else begin
            w_f16 = w_w[31] ? (16'd0 - w_mag) : w_mag;
        end
    end

    always_comb begin
        o_out.status           = psfc_pkg::STATUS_OK;
        o_out.converted_sample = 32'sd0;
        if (i_src_fmt == psfc_pkg::FMT_S16 && i_tgt_fmt == psfc_pkg::TGT_S32) begin
            o_out.converted_sample = {w_w[15:0], 16'd0};
        end else if (i_src_fmt == psfc_pkg::FMT_S32 && i_tgt_fmt == psfc_pkg::TGT_S16) begin
            o_out.converted_sample = {{16{w_w[31]}}, w_w[31:16]};
        end else if (i_src_fmt == psfc_pkg::FMT_FLT && i_tgt_fmt == psfc_pkg::TGT_S16) begin
            o_out.converted_sample = {{16{w_f16[15]}}, w_f16};
        end else if (i_in.planar_source && i_src_fmt == psfc_pkg::FMT_S16
                     && i_tgt_fmt == psfc_pkg::TGT_S16) begin
            o_out.converted_sample = {{16{w_w[15]}}, w_w[15:0]};
        end else if (i_in.planar_source && i_src_fmt == psfc_pkg::FMT_S32
                     && i_tgt_fmt == psfc_pkg::TGT_S32) begin
            o_out.converted_sample = w_w;
        end else begin
            o_out.status = psfc_pkg::STATUS_UNSUP;
        end
    end
endmodule
`default_nettype wire

@@ src/pcm_sample_format_converter.sv @@
// top level of the pcm sample format converter
// channel   | transfer when            | payload
// sample in | start & !busy            | i_sample (t_in)
// result    | o_done                   | o_result (t_out)
// config    | psel&penable&pwrite      | paddr, pwdata
// one sample per cycle; each result passes the input register and then the
// result register around the conversion logic
// busy is always low; the receiver cannot stall results
// synchronous active-low reset clears valid flags and formats to signed 16
`timescale 1ns / 1ps
`default_nettype none
`include "pcm_sample_format_converter_macros.svh"
module pcm_sample_format_converter (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire psfc_pkg::t_in  i_sample,
    output logic                o_done,
    output psfc_pkg::t_out      o_result,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic [1:0]     r_src_fmt;
    logic           r_tgt_fmt;
    logic           r_in_vld;
    psfc_pkg::t_in  r_in;
    logic           r_out_vld;
    psfc_pkg::t_out r_out;
    psfc_pkg::t_out n_out;
    logic           w_wr;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= psfc_pkg::FMT_S16;
            r_tgt_fmt <= psfc_pkg::TGT_S16;
        end else if (w_wr) begin
            if (paddr[2] == psfc_pkg::REG_SOURCE) begin
                r_src_fmt <= pwdata[1:0];
            end else begin
                r_tgt_fmt <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == psfc_pkg::REG_SOURCE) begin
            prdata = {30'd0, r_src_fmt};
        end else begin
            prdata = {31'd0, r_tgt_fmt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start & ~busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start & ~busy) begin
            r_in <= i_sample;
        end
        r_out <= n_out;
    end

    psfc_conv u_conv (
        .i_in      (r_in),
        .i_src_fmt (r_src_fmt),
        .i_tgt_fmt (r_tgt_fmt),
        .o_out     (n_out)
    );

    assign o_done   = r_out_vld;
    assign o_result = r_out;

    `PSFC_ASSERT_NEXT(a_in_reg, i_clk, i_rst_n, start && !busy, r_in_vld)
    `PSFC_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, r_in_vld, o_done)
    `PSFC_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_done && o_result.status, o_result.converted_sample == 32'sd0)
endmodule
`default_nettype wire

@@ test/pcm_sample_format_converter_checker.sv @@
// checker for the pcm sample format converter: predicts results and compares them
`timescale 1ns / 1ps
module pcm_sample_format_converter_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire logic           busy,
    input  wire psfc_pkg::t_in  i_sample,
    input  wire logic           o_done,
    input  wire psfc_pkg::t_out o_result,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic           pready,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output int                  o_fail_count,
    output int                  o_pending
);
    import psfc_pkg::*;

    logic [1:0] src_fmt;
    logic       tgt_fmt;
    t_out       expected_results[$];

    // single-precision product rounded to nearest even, then truncated toward zero
    function automatic logic signed [31:0] float_to_s16(logic [31:0] bits);
        logic [63:0] prod;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        int          e;
        int          drop;
        int          sh;
        e = int'(bits[30:23]);
        if (e == 255 && bits[22:0] != 23'd0) return 0;
        if (bits[30:0] > 31'h3F80_0000) return bits[31] ? -32768 : 32767;
        if (e == 0) return 0;
        prod = {40'd0, 1'b1, bits[22:0]} * 64'd32767;
        drop = prod[38] ? 15 : 14;
        kept = prod >> drop;
        rem  = prod & ((64'd1 << drop) - 64'd1);
        half = 64'd1 << (drop - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
        sh  = 150 - e - drop;
        mag = (sh >= 64) ? 64'd0 : (kept >> sh);
        return bits[31] ? -32'(mag) : 32'(mag);
    endfunction

    function automatic t_out convert_sample(t_in s);
        t_out r;
        r.status = STATUS_OK;
        r.converted_sample = 0;
        if (src_fmt == FMT_S16 && tgt_fmt == TGT_S32)
            r.converted_sample = {s.sample_word[15:0], 16'h0};
        else if (src_fmt == FMT_S32 && tgt_fmt == TGT_S16)
            r.converted_sample = {{16{s.sample_word[31]}}, s.sample_word[31:16]};
        else if (src_fmt == FMT_FLT && tgt_fmt == TGT_S16)
            r.converted_sample = float_to_s16(s.sample_word);
        else if (s.planar_source && src_fmt == FMT_S16 && tgt_fmt == TGT_S16)
            r.converted_sample = {{16{s.sample_word[15]}}, s.sample_word[15:0]};
        else if (s.planar_source && src_fmt == FMT_S32 && tgt_fmt == TGT_S32)
            r.converted_sample = s.sample_word;
        else
            r.status = STATUS_UNSUP;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            src_fmt <= FMT_S16;
            tgt_fmt <= TGT_S16;
        end else begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", o_result, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.converted_sample !== want.converted_sample)
                        report_mismatch("sample", o_result.converted_sample,
                                        want.converted_sample);
                    if (o_result.status !== want.status)
                        report_mismatch("status", o_result.status, want.status);
                end
            end
            if (start && !busy)
                expected_results.push_back(convert_sample(i_sample));
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SOURCE) src_fmt <= pwdata[1:0];
                else tgt_fmt <= pwdata[0];
            end
        end
    end
endmodule

@@ test/tb.sv @@
// testbench top for the pcm sample format converter
`timescale 1ns / 1ps
module tb;
    import psfc_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    t_in         i_sample = '0;
    logic        o_done;
    t_out        o_result;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    pcm_sample_format_converter dut (.*);

    pcm_sample_format_converter_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_sample, .o_done, .o_result,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic drain_results();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic reg_idx, logic [31:0] value);
        drain_results();
        psel <= 1; pwrite <= 1; paddr <= {reg_idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_sample(logic [31:0] word, logic planar);
        int gap;
        i_sample <= '{sample_word: word, planar_source: planar};
        start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] random_word(logic [1:0] fmt);
        logic [31:0] w;
        w = $urandom;
        if (fmt == FMT_FLT) begin
            case ($urandom_range(0, 5))
                0: w = {w[31], 8'd127, 23'd0};
                1: w = {w[31], 8'd255, $urandom_range(0, 1) ? w[22:0] : 23'd0};
                2: w = {w[31], 8'($urandom_range(100, 128)), w[22:0]};
                3: w = {w[31], 8'd126, w[22:0]};
                default: ;
            endcase
        end
        return w;
    endfunction

    logic [31:0] directed_words[] = '{32'h0, 32'hffffffff, 32'h7fff8000, 32'h80007fff,
                                      32'h3f800000, 32'hbf800000, 32'h7f800000,
                                      32'hff800000, 32'h7fc00001, 32'h3f000000,
                                      32'h3f800001, 32'h00000001};

    initial begin
        logic [1:0] fmt;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        for (int s = 0; s < 4; s++) begin
            for (int t = 0; t < 2; t++) begin
                write_reg(REG_SOURCE, s);
                write_reg(REG_TARGET, t);
                foreach (directed_words[k])
                    if (k % 4 == (s + t) % 4 || s == FMT_FLT)
                        send_sample(directed_words[k], k[0]);
                start <= 0;
            end
        end
        for (int ph = 0; ph < 8; ph++) begin
            fmt = (ph < 2) ? FMT_FLT : 2'($urandom_range(0, 3));
            write_reg(REG_SOURCE, {$urandom_range(0, 1) ? 30'h3fffffff : 30'h0, fmt});
            write_reg(REG_TARGET, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hffffffff : $urandom);
            for (int n = 0; n < 50; n++) send_sample(random_word(fmt), $urandom_range(0, 1));
            start <= 0;
            if (ph == 3) drain_results();
        end
        start <= 0;
        drain_results();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+src
src/psfc_pkg.sv
src/psfc_conv.sv
src/pcm_sample_format_converter.sv
test/pcm_sample_format_converter_checker.sv
test/tb.sv
